// ===== src/jvl_pkg.sv =====
// Shared constants, types and helpers of the joint velocity limiter.
// No dependencies; used by every module of the block.
`default_nettype none

package jvl_pkg;

   // Block configuration
   localparam int JOINT_COUNT    = 8;
   localparam int VELOCITY_WIDTH = 16;
   localparam int JOINT_SLOTS    = 8;
   localparam int REG_W          = 32;
   localparam int LIMIT_W        = 16;

   // Ratio arithmetic: unsigned Q0.16 plus one bit so that 1.0 fits
   localparam int RATIO_BITS         = 16;
   localparam int RATIO_W            = RATIO_BITS + 1;
   localparam int DIV_BITS_PER_CYCLE = 2;
   localparam int DIV_ITERS          = RATIO_BITS / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W          = $clog2(DIV_ITERS + 1);

   // Derived widths
   localparam int JOINT_IDX_W = $clog2(JOINT_COUNT);
   localparam int CSR_IDX_W   = $clog2(JOINT_SLOTS);
   localparam int REM_W       = VELOCITY_WIDTH + 1;
   localparam int PROD_W      = VELOCITY_WIDTH + RATIO_W;
   localparam int CMP_W       = ((VELOCITY_WIDTH > LIMIT_W) ? VELOCITY_WIDTH : LIMIT_W) + 1;
   localparam int SUM_W       = CMP_W + 2;
   localparam int DATA_W      = JOINT_SLOTS * VELOCITY_WIDTH;

   localparam logic [REG_W-1:0]   LIMITS_RESET = 32'h7FFF_7FFF;
   localparam logic [RATIO_W-1:0] RATIO_ONE    = RATIO_W'(1) << RATIO_BITS;

   typedef logic signed [VELOCITY_WIDTH-1:0] vel_type;
   typedef logic [VELOCITY_WIDTH-1:0]        mag_type;
   typedef logic [LIMIT_W-1:0]               limit_type;
   typedef logic [RATIO_W-1:0]               ratio_type;
   typedef logic [JOINT_IDX_W-1:0]           joint_idx_type;

   // One joint handed to the limit pipeline
   typedef struct packed {
      logic          valid;
      joint_idx_type idx;
      vel_type       vel;
      ratio_type     ratio;
      limit_type     lim;
      limit_type     step;
      vel_type       prev;
   } issue_type;

   // One limited joint coming back for write-back
   typedef struct packed {
      logic          valid;
      joint_idx_type idx;
      vel_type       value;
   } result_type;

   // Magnitude; the most negative value maps to 2^(w-1) unsigned
   function automatic mag_type vel_mag(input vel_type v);
      vel_type neg_v;
      neg_v = -v;
      return v[VELOCITY_WIDTH-1] ? mag_type'(neg_v) : mag_type'(v);
   endfunction

endpackage

`default_nettype wire

// ===== src/joint_velocity_limiter_top.sv =====
// Each input item is scanned joint by joint; every joint that is over its speed limit takes
// a pass through the shared ratio divider (2 quotient bits per cycle), then the joints are
// streamed through the limit pipeline. The next item can be accepted once the result has
// been loaded; a finished result waits in the output register while the next item is
// accepted. Synchronous active-high reset: limits go to 0x7FFF7FFF, previous outputs to
// zero, nothing in flight.
`default_nettype none

module joint_velocity_limiter_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // velocity_0 .. velocity_7, 16 bits each, from the lowest bit up
   input  wire logic [jvl_pkg::DATA_W-1:0]    req_tdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // limited_0 .. limited_7, 16 bits each, from the lowest bit up
   output logic [jvl_pkg::DATA_W-1:0]         rsp_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic                          csr_wr_en,
   input  wire logic [jvl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [jvl_pkg::REG_W-1:0]     csr_wr_data
);

   localparam int VW = jvl_pkg::VELOCITY_WIDTH;
   localparam int JC = jvl_pkg::JOINT_COUNT;
   localparam jvl_pkg::joint_idx_type JOINT_LAST = jvl_pkg::JOINT_IDX_W'(JC - 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_APPLY = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   jvl_pkg::joint_idx_type         joint_ff, joint_in;
   jvl_pkg::ratio_type             ratio_ff, ratio_in;
   logic [jvl_pkg::REG_W-1:0]      limits_ff [JC];
   jvl_pkg::vel_type               prev_ff   [JC];
   jvl_pkg::vel_type               vel_ff    [JC];
   logic                           rsp_valid_ff;
   logic [jvl_pkg::DATA_W-1:0]     rsp_data_ff;
   logic [jvl_pkg::DATA_W-1:0]     pack_data;

   logic                           req_accept;
   logic                           rsp_load;
   logic                           div_start;
   logic                           div_busy;
   logic                           div_done;
   jvl_pkg::limit_type             div_quo;
   jvl_pkg::mag_type               cur_mag;
   jvl_pkg::limit_type             cur_lim;
   logic                           over_limit;
   logic                           last_joint;
   jvl_pkg::issue_type             issue;
   jvl_pkg::result_type            result;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Current joint as seen by the sequencer
   assign cur_mag    = jvl_pkg::vel_mag(vel_ff[joint_ff]);
   assign cur_lim    = limits_ff[joint_ff][jvl_pkg::LIMIT_W-1:0];
   assign over_limit = jvl_pkg::CMP_W'(cur_mag) > jvl_pkg::CMP_W'(cur_lim);
   assign last_joint = (joint_ff == JOINT_LAST);

   // Configuration registers; indexes past the joint count are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < JC; i++) begin
            limits_ff[i] <= jvl_pkg::LIMITS_RESET;
         end
      end else if (csr_wr_en &&
                   ({1'b0, csr_index} < (jvl_pkg::CSR_IDX_W + 1)'(JC))) begin
         limits_ff[csr_index[jvl_pkg::JOINT_IDX_W-1:0]] <= csr_wr_data;
      end
   end

   // Input item capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < JC; i++) begin
            vel_ff[i] <= req_tdata[i*VW +: VW];
         end
      end
   end

   // Sequencer: scan for the smallest ratio, then stream joints through limits
   always_comb begin
      state_in  = state_ff;
      joint_in  = joint_ff;
      ratio_in  = ratio_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      issue     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               joint_in = '0;
               ratio_in = jvl_pkg::RATIO_ONE;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (over_limit) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (last_joint) begin
               joint_in = '0;
               state_in = ST_APPLY;
            end else begin
               joint_in = joint_ff + jvl_pkg::JOINT_IDX_W'(1);
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (jvl_pkg::RATIO_W'(div_quo) < ratio_ff) begin
                  ratio_in = jvl_pkg::RATIO_W'(div_quo);
               end
               if (last_joint) begin
                  joint_in = '0;
                  state_in = ST_APPLY;
               end else begin
                  joint_in = joint_ff + jvl_pkg::JOINT_IDX_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_APPLY: begin
            issue.valid = 1'b1;
            issue.idx   = joint_ff;
            issue.vel   = vel_ff[joint_ff];
            issue.ratio = ratio_ff;
            issue.lim   = cur_lim;
            issue.step  = limits_ff[joint_ff][jvl_pkg::LIMIT_W +: jvl_pkg::LIMIT_W];
            issue.prev  = prev_ff[joint_ff];
            if (last_joint) begin
               state_in = ST_DRAIN;
            end else begin
               joint_in = joint_ff + jvl_pkg::JOINT_IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (result.valid && (result.idx == JOINT_LAST)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         joint_ff <= '0;
         ratio_ff <= jvl_pkg::RATIO_ONE;
      end else begin
         state_ff <= state_in;
         joint_ff <= joint_in;
         ratio_ff <= ratio_in;
      end
   end

   // Shared ratio divider
   jvl_ratio_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .limit    (cur_lim),
      .divisor  (cur_mag),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Shared limit pipeline
   jvl_limit_unit u_limit (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .result (result)
   );

   // Previous output vector, written back joint by joint
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < JC; i++) begin
            prev_ff[i] <= '0;
         end
      end else if (result.valid) begin
         prev_ff[result.idx] <= result.value;
      end
   end

   // Output packing; unused slots read zero
   for (genvar g = 0; g < jvl_pkg::JOINT_SLOTS; g++) begin : g_pack
      if (g < JC) begin : g_used
         assign pack_data[g*VW +: VW] = prev_ff[g];
      end else begin : g_unused
         assign pack_data[g*VW +: VW] = '0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= pack_data;
      end
   end

   // Checks
   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == ST_DIV))
      else $error("divider busy outside the divide state");

   a_result_in_apply: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (state_ff == ST_APPLY || state_ff == ST_DRAIN))
      else $error("limit result outside apply or drain");

   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      ratio_ff <= jvl_pkg::RATIO_ONE)
      else $error("scale ratio above one");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

endmodule

`default_nettype wire

// ===== src/jvl_ratio_div.sv =====
// Iterative restoring divider for the scale ratio limit * 2^16 / |v|.
// Two quotient bits per cycle; depends on jvl_pkg.
`default_nettype none

module jvl_ratio_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire jvl_pkg::limit_type limit,
   input  wire jvl_pkg::mag_type   divisor,
   output logic                    busy,
   output logic                    done,
   output jvl_pkg::limit_type      quotient
);

   logic [jvl_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [jvl_pkg::REM_W-1:0]     dvs_ff;
   jvl_pkg::limit_type            quo_ff, quo_in;
   logic [jvl_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;

   // Combinational shift-subtract steps; remainder stays below the divisor
   always_comb begin
      logic [jvl_pkg::REM_W-1:0] shifted;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int k = 0; k < jvl_pkg::DIV_BITS_PER_CYCLE; k++) begin
         shifted = {rem_in[jvl_pkg::REM_W-2:0], 1'b0};
         if (shifted >= dvs_ff) begin
            rem_in = shifted - dvs_ff;
            quo_in = {quo_in[jvl_pkg::LIMIT_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_in[jvl_pkg::LIMIT_W-2:0], 1'b0};
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= jvl_pkg::DIV_CNT_W'(jvl_pkg::DIV_ITERS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - jvl_pkg::DIV_CNT_W'(1);
            if (cnt_ff == jvl_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath; limit is below the divisor, so it is the first remainder
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= jvl_pkg::REM_W'(limit);
         dvs_ff <= jvl_pkg::REM_W'(divisor);
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== src/jvl_limit_unit.sv =====
// Three-stage limit pipeline shared by all joints: scale multiply,
// speed clamp and difference, step limit and saturation. Depends on jvl_pkg.
`default_nettype none

module jvl_limit_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire jvl_pkg::issue_type issue,
   output jvl_pkg::result_type     result
);

   localparam int VW = jvl_pkg::VELOCITY_WIDTH;
   localparam int SW = jvl_pkg::SUM_W;
   localparam int CW = jvl_pkg::CMP_W;
   localparam logic signed [SW-1:0] SAT_MAX =
      $signed({{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}});
   localparam logic signed [SW-1:0] SAT_MIN =
      $signed({{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}});

   // Stage 1: |v| times ratio
   logic                          s1_valid_ff;
   jvl_pkg::joint_idx_type        s1_idx_ff;
   logic                          s1_neg_ff;
   logic [jvl_pkg::PROD_W-1:0]    s1_prod_ff, s1_prod_in;
   jvl_pkg::limit_type            s1_lim_ff;
   jvl_pkg::limit_type            s1_step_ff;
   jvl_pkg::vel_type              s1_prev_ff;

   assign s1_prod_in = jvl_pkg::PROD_W'(jvl_pkg::vel_mag(issue.vel))
                       * jvl_pkg::PROD_W'(issue.ratio);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.valid) begin
         s1_idx_ff  <= issue.idx;
         s1_neg_ff  <= issue.vel[VW-1];
         s1_prod_ff <= s1_prod_in;
         s1_lim_ff  <= issue.lim;
         s1_step_ff <= issue.step;
         s1_prev_ff <= issue.prev;
      end
   end

   // Stage 2: truncate, clamp to the speed limit, restore sign, difference
   logic                    s2_valid_ff;
   jvl_pkg::joint_idx_type  s2_idx_ff;
   jvl_pkg::limit_type      s2_step_ff;
   jvl_pkg::vel_type        s2_prev_ff;
   logic signed [SW-1:0]    s2_x_ff, s2_x_in;
   logic signed [SW-1:0]    s2_d_ff, s2_d_in;

   always_comb begin
      jvl_pkg::mag_type     scaled;
      logic [CW-1:0]        clamped;
      logic signed [SW-1:0] x_pos;
      scaled = s1_prod_ff[jvl_pkg::RATIO_BITS +: VW];
      if (CW'(scaled) > CW'(s1_lim_ff)) begin
         clamped = CW'(s1_lim_ff);
      end else begin
         clamped = CW'(scaled);
      end
      x_pos   = $signed(SW'(clamped));
      s2_x_in = s1_neg_ff ? -x_pos : x_pos;
      s2_d_in = s2_x_in - SW'(s1_prev_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_idx_ff  <= s1_idx_ff;
         s2_step_ff <= s1_step_ff;
         s2_prev_ff <= s1_prev_ff;
         s2_x_ff    <= s2_x_in;
         s2_d_ff    <= s2_d_in;
      end
   end

   // Stage 3: step limit (zero difference counts as positive), saturate
   jvl_pkg::result_type result_ff, result_in;

   always_comb begin
      logic [SW-1:0]        d_mag;
      logic signed [SW-1:0] step_s;
      logic signed [SW-1:0] y;
      d_mag  = SW'(s2_d_ff[SW-1] ? -s2_d_ff : s2_d_ff);
      step_s = $signed(SW'(s2_step_ff));
      if (d_mag > SW'(s2_step_ff)) begin
         y = SW'(s2_prev_ff) + (s2_d_ff[SW-1] ? -step_s : step_s);
      end else begin
         y = s2_x_ff;
      end
      if (y > SAT_MAX) begin
         y = SAT_MAX;
      end else if (y < SAT_MIN) begin
         y = SAT_MIN;
      end
      result_in.valid = s2_valid_ff;
      result_in.idx   = s2_idx_ff;
      result_in.value = y[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff.valid <= 1'b0;
      end else begin
         result_ff.valid <= result_in.valid;
      end
      if (s2_valid_ff) begin
         result_ff.idx   <= result_in.idx;
         result_ff.value <= result_in.value;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== tb/tb_joint_velocity_limiter_top.sv =====
// Self-checking testbench for joint_velocity_limiter_top: drives velocity vectors and
// per-joint limit registers, predicts every limited vector and compares it field by field.
// Depends on jvl_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_joint_velocity_limiter_top;
   import jvl_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 120;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 72;
   localparam int REPORT_LIMIT  = 10;

   typedef logic [DATA_W-1:0] vel_vector_type;

   // Speed/step scaling predictor plus the queue of limited vectors still owed
   class velocity_limit_checker;
      logic [REG_W-1:0] joint_limits [JOINT_SLOTS];
      vel_type          last_output [JOINT_SLOTS];
      vel_vector_type   expected_limited_q [$];
      int               mismatches;

      function new();
         for (int i = 0; i < JOINT_SLOTS; i++) begin
            joint_limits[i] = LIMITS_RESET;
            last_output[i]  = '0;
         end
         mismatches = 0;
      endfunction

      function void write_limits(int idx, logic [REG_W-1:0] value);
         if (idx < JOINT_SLOTS) joint_limits[idx] = value;
      endfunction

      // Common scaling, per-joint clamp, then step limit against the last output
      function vel_vector_type predict_limited(vel_vector_type command);
         longint cmd_v [JOINT_SLOTS];
         longint scale_q16, ratio, mag_v, lim, step, x, d, hi, lo;
         bit over_any;
         vel_vector_type result;
         result    = '0;
         scale_q16 = longint'(1) << RATIO_BITS;
         over_any  = 1'b0;
         hi        = (longint'(1) << (VELOCITY_WIDTH - 1)) - 1;
         lo        = -hi - 1;
         for (int i = 0; i < JOINT_COUNT; i++) begin
            cmd_v[i] = longint'(vel_type'(command[i*VELOCITY_WIDTH +: VELOCITY_WIDTH]));
            mag_v    = (cmd_v[i] < 0) ? -cmd_v[i] : cmd_v[i];
            lim      = longint'(joint_limits[i][LIMIT_W-1:0]);
            if (mag_v > lim) begin
               ratio = (lim << RATIO_BITS) / mag_v;
               if (ratio < scale_q16) scale_q16 = ratio;
               over_any = 1'b1;
            end
         end
         for (int i = 0; i < JOINT_COUNT; i++) begin
            lim  = longint'(joint_limits[i][LIMIT_W-1:0]);
            step = longint'(joint_limits[i][REG_W-1:LIMIT_W]);
            x    = cmd_v[i];
            if (over_any) begin
               mag_v = (((x < 0) ? -x : x) * scale_q16) >> RATIO_BITS;
               x     = (x < 0) ? -mag_v : mag_v;
            end
            mag_v = (x < 0) ? -x : x;
            if (mag_v > lim) x = (x < 0) ? -lim : lim;
            d = x - longint'(last_output[i]);
            if (((d < 0) ? -d : d) > step)
               x = longint'(last_output[i]) + ((d >= 0) ? step : -step);
            if (x > hi) x = hi;
            if (x < lo) x = lo;
            last_output[i] = vel_type'(x);
            result[i*VELOCITY_WIDTH +: VELOCITY_WIDTH] = vel_type'(x);
         end
         return result;
      endfunction

      function void note_command(vel_vector_type command);
         expected_limited_q.push_back(predict_limited(command));
      endfunction

      function void check_limited(vel_vector_type got);
         vel_vector_type want;
         vel_type want_f, got_f;
         if (expected_limited_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected limited vector %h", got);
            return;
         end
         want = expected_limited_q.pop_front();
         for (int i = 0; i < JOINT_SLOTS; i++) begin
            want_f = want[i*VELOCITY_WIDTH +: VELOCITY_WIDTH];
            got_f  = got[i*VELOCITY_WIDTH +: VELOCITY_WIDTH];
            if (want_f !== got_f) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("limited_%0d mismatch: expected %0d, got %0d", i, want_f, got_f);
            end
         end
      endfunction

      function int pending();
         return expected_limited_q.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   vel_vector_type       req_tdata;
   logic                 req_tvalid;
   logic                 req_tready;
   vel_vector_type       rsp_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wr_data;

   velocity_limit_checker limiter;
   bit steady_phase;
   int idle_cycles;
   int ready_hold;

   joint_velocity_limiter_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Result side: random back-pressure, mostly short stalls, a few long ones
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
         ready_hold = 0;
      end else if (steady_phase) begin
         rsp_tready = 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            rsp_tready = 1'b1;
            ready_hold = $urandom_range(0, 6);
         end else if (pick < 93) begin
            rsp_tready = 1'b0;
            ready_hold = $urandom_range(0, 3);
         end else begin
            rsp_tready = 1'b0;
            ready_hold = $urandom_range(20, 120);
         end
      end
   end

   // Compare each accepted result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) limiter.check_limited(rsp_tdata);
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady_phase || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_extreme16();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'h7FFF;
         3: return 16'h8000;
         4: return 16'hFFFF;
         default: return LIMIT_W'($urandom);
      endcase
   endfunction

   // Velocity vector: random, extreme or shaped around the current limits
   function automatic vel_vector_type make_command(int mode);
      vel_vector_type cmd;
      int bound, v;
      for (int i = 0; i < JOINT_SLOTS; i++) begin
         bound = int'(limiter.joint_limits[i][LIMIT_W-1:0]);
         if (bound > 32767) bound = 32767;
         case (mode)
            0: v = int'(vel_type'($urandom));
            1: v = int'($urandom_range(0, 2 * bound)) - bound;
            2: begin
               v = bound + int'($urandom_range(0, 64)) - 32;
               if (v > 32767) v = 32767;
               if (v < 0) v = 0;
               if ($urandom_range(0, 1)) v = -v - int'($urandom_range(0, 1));
            end
            default: begin
               case ($urandom_range(0, 5))
                  0: v = -32768;
                  1: v = -32767;
                  2: v = -1;
                  3: v = 0;
                  4: v = 1;
                  default: v = 32767;
               endcase
            end
         endcase
         cmd[i*VELOCITY_WIDTH +: VELOCITY_WIDTH] = vel_type'(v);
      end
      return cmd;
   endfunction

   // One velocity item, after an optional gap; valid stays high when the gap is zero
   task automatic send_command(input vel_vector_type cmd, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = cmd;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      limiter.note_command(cmd);
   endtask

   // Stop sending and wait until every limited vector has come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (limiter.pending() != 0) @(posedge clock);
   endtask

   task automatic write_limits(input int idx, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = CSR_IDX_W'(idx);
      csr_wr_data = value;
      @(posedge clock);
      limiter.write_limits(idx, value);
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_uniform(input int value);
      vel_vector_type cmd;
      for (int i = 0; i < JOINT_SLOTS; i++)
         cmd[i*VELOCITY_WIDTH +: VELOCITY_WIDTH] = vel_type'(value);
      send_command(cmd, pick_gap());
   endtask

   initial begin
      vel_vector_type cmd;
      logic [LIMIT_W-1:0] lim_f, step_f;
      int kind, pick;
      limiter      = new();
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wr_data  = '0;
      steady_phase = 1'b0;
      idle_cycles  = 0;
      ready_hold   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, reset limits: extremes, most negative value forces scaling
      send_uniform(0);
      send_uniform(32767);
      send_uniform(-32768);
      send_uniform(0);
      cmd = '0;
      cmd[3*VELOCITY_WIDTH +: VELOCITY_WIDTH] = 16'h8000;
      cmd[5*VELOCITY_WIDTH +: VELOCITY_WIDTH] = 16'h1234;
      send_command(cmd, 0);
      send_command({4{16'h8000, 16'h7FFF}}, 0);
      drain_results();

      // Directed limits: zero speed limit, zero step, full-scale fields
      write_limits(0, {16'h7FFF, 16'h0000});
      write_limits(1, {16'h0000, 16'h4000});
      write_limits(2, {16'hFFFF, 16'hFFFF});
      write_limits(3, {16'h0001, 16'h0001});
      write_limits(4, {16'h8000, 16'h8000});
      for (int i = 5; i < JOINT_SLOTS; i++) write_limits(i, {16'h1000, 16'h2000});
      end_writes();
      send_uniform(16384);
      send_uniform(0);
      cmd = {8{16'h4000}};
      cmd[0 +: VELOCITY_WIDTH] = '0;
      send_command(cmd, 0);
      send_uniform(-16384);
      send_command(cmd, 0);
      send_uniform(-32768);
      send_uniform(32767);
      send_uniform(1);
      send_uniform(-1);
      drain_results();

      // Same limits but joint 0 open: scaling and clamping without the zero-limit collapse
      write_limits(0, {16'h0400, 16'h3000});
      end_writes();
      send_uniform(32767);
      send_uniform(-32768);
      send_uniform(0);
      drain_results();

      // Random phases cycling through realistic, full-range and extreme limits
      for (int p = 0; p < PHASE_COUNT; p++) begin
         kind = p % 3;
         for (int i = 0; i < JOINT_SLOTS; i++) begin
            case (kind)
               0: begin
                  lim_f  = ($urandom_range(0, 15) == 0) ? 16'h0000
                                                        : LIMIT_W'($urandom_range(16'h0400, 16'h6000));
                  step_f = LIMIT_W'($urandom_range(16'h0080, 16'h2000));
               end
               1: begin
                  lim_f  = LIMIT_W'($urandom);
                  step_f = LIMIT_W'($urandom);
               end
               default: begin
                  lim_f  = pick_extreme16();
                  step_f = pick_extreme16();
               end
            endcase
            write_limits(i, {step_f, lim_f});
         end
         end_writes();
         steady_phase = (p == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)      cmd = make_command(0);
            else if (pick < 60) cmd = make_command(1);
            else if (pick < 85) cmd = make_command(2);
            else                cmd = make_command(3);
            send_command(cmd, pick_gap());
            if ($urandom_range(0, 49) == 0) drain_results();
         end
         drain_results();
         steady_phase = 1'b0;
      end

      // Let anything stray show up, then report
      repeat (DRAIN_CYCLES) @(posedge clock);
      limiter.mismatches += limiter.pending();
      if (limiter.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
